>>> rtl/core/cel_pkg.sv
// shared definitions for the csr edge lookup block
// operation codes, register indexes and default store depths
// no dependencies
package cel_pkg;

  // default store depths
  localparam int MAX_NODES_DEF = 4096;
  localparam int MAX_EDGES_DEF = 65536;

  // field widths
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int VAL_W     = 32;
  localparam int ID_W      = 32;
  localparam int IDX_W     = 17;   // local edge index, holds the edge count itself
  localparam int NNODES_W  = 13;
  localparam int EIDX_W    = 16;
  localparam int CFG_AW    = 8;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_WR_NODE = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_NODE_OFFSET = 8'd0;
  localparam logic [CFG_AW-1:0] CFG_EDGE_OFFSET = 8'd1;
  localparam logic [CFG_AW-1:0] CFG_NUM_EDGES   = 8'd2;
  localparam logic [CFG_AW-1:0] CFG_NUM_NODES   = 8'd3;

endpackage

>>> rtl/core/csr_edge_lookup_unit.sv
// edge search over one part of a compressed-sparse-row graph
// holds the row end store and the edge destination store in two cel_ram instances
// depends on cel_pkg and cel_ram
//
// write transactions: taken back to back while idle, no result
// query: reads the row ends of p-1 and p, then scans the edge destinations of
//   the range, one edge destination read per cycle, and stops at the first hit
// out-of-range query: skips the reads; one query in flight at a time,
//   the next transaction is taken in the cycle after the result register loads
// reset: control and config registers clear, stores are not cleared
module csr_edge_lookup_unit #(
  parameter int MAX_NODES = cel_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = cel_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] write_addr, [47:16] write_value, [79:48] src_node, [111:80] dst_node
  input  logic [cel_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] operation
  input  logic [cel_pkg::OP_W-1:0]        in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] found, [16:1] edge_index, [17] out_of_range, [23:18] zero
  output logic [cel_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cel_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [31:0]                     cfg_data
);

  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int IW  = cel_pkg::IDX_W;

  // query sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;  // range check, read row end of p-1
  localparam logic [2:0] S_RE   = 3'd2;  // take begin, read row end of p
  localparam logic [2:0] S_EC   = 3'd3;  // take end
  localparam logic [2:0] S_SCAN = 3'd4;  // stream edge destinations, compare
  localparam logic [2:0] S_FIN  = 3'd5;  // wait for the result register

  // input field unpacking
  logic [cel_pkg::OP_W-1:0]   op;
  logic [cel_pkg::ADDR_W-1:0] wr_addr;
  logic [cel_pkg::VAL_W-1:0]  wr_value;
  logic [cel_pkg::ID_W-1:0]   src_node;
  logic [cel_pkg::ID_W-1:0]   dst_node;

  assign op       = in_tuser;
  assign wr_addr  = in_tdata[15:0];
  assign wr_value = in_tdata[47:16];
  assign src_node = in_tdata[79:48];
  assign dst_node = in_tdata[111:80];

  // configuration registers and derived limits
  logic [31:0]                   node_offset_r;
  logic [31:0]                   edge_base_r;
  logic [IW-1:0]                 edge_cnt_r;
  logic [cel_pkg::NNODES_W-1:0]  num_nodes_r;
  logic [32:0]                   limit_r;   // edge base + edge count
  logic [IW-1:0]                 elim_r;    // min(edge count, MAX_EDGES)

  // sequencer registers
  logic [2:0]     state_r, state_nxt;
  logic [31:0]    p_r, p_nxt;
  logic           pbor_r, pbor_nxt;     // source below node offset
  logic [31:0]    dst_r, dst_nxt;
  logic [IW-1:0]  b_r, b_nxt;
  logic [IW-1:0]  e_r, e_nxt;
  logic [IW-1:0]  issue_r, issue_nxt;
  logic [IW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic           res_found_r, res_found_nxt;
  logic [15:0]    res_idx_r, res_idx_nxt;
  logic           res_oor_r, res_oor_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [15:0]    out_idx_r, out_idx_nxt;
  logic           out_oor_r, out_oor_nxt;

  // ram ports
  logic            node_we, node_re;
  logic [NAW-1:0]  node_waddr, node_raddr;
  logic [31:0]     node_rdata;
  logic            edge_we, edge_re;
  logic [EAW-1:0]  edge_waddr, edge_raddr;
  logic [31:0]     edge_rdata;

  logic            in_acc;
  logic [31:0]     wr_addr_ext;
  logic [31:0]     pm1;
  logic [31:0]     issue_ext;
  logic [32:0]     p_diff;
  logic            issue_ok;
  logic            hit;
  logic            oor;
  logic            slot_free;

  // clamp a global edge index to the held edges and make it local,
  // saturating at zero below the edge base
  function automatic logic [IW-1:0] local_edge(input logic [31:0] g,
                                               input logic [31:0] eo,
                                               input logic [32:0] lim,
                                               input logic [IW-1:0] ne);
    logic [32:0] diff;
    logic [IW-1:0] res;
    diff = {1'b0, g} - {1'b0, eo};
    if (diff[32]) begin
      res = '0;
    end else if ({1'b0, g} > lim) begin
      res = ne;
    end else begin
      res = diff[IW-1:0];
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // writes are taken only between queries, so a store is never written
  // while a query reads it
  assign wr_addr_ext = {16'd0, wr_addr};
  assign node_we     = in_acc && (op == cel_pkg::OP_WR_NODE) &&
                       (wr_addr_ext < 32'(MAX_NODES));
  assign edge_we     = in_acc && (op == cel_pkg::OP_WR_EDGE) &&
                       (wr_addr_ext < 32'(MAX_EDGES));
  assign node_waddr  = wr_addr_ext[NAW-1:0];
  assign edge_waddr  = wr_addr_ext[EAW-1:0];

  assign pm1        = p_r - 32'd1;
  assign node_raddr = (state_r == S_CHK) ? pm1[NAW-1:0] : p_r[NAW-1:0];
  assign issue_ext  = {{(32-IW){1'b0}}, issue_r};
  assign edge_raddr = issue_ext[EAW-1:0];

  assign p_diff   = {1'b0, src_node} - {1'b0, node_offset_r};
  // scan stays inside the range and inside the store
  assign issue_ok = (issue_r < e_r) && (issue_r < elim_r);
  assign hit      = cmp_vld_r && (edge_rdata == dst_r);
  assign oor      = pbor_r || (p_r >= {19'd0, num_nodes_r}) ||
                    (p_r >= 32'(MAX_NODES));
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    pbor_nxt      = pbor_r;
    dst_nxt       = dst_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    issue_nxt     = issue_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_oor_nxt   = res_oor_r;
    node_re       = 1'b0;
    edge_re       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (op == cel_pkg::OP_QUERY)) begin
          p_nxt     = p_diff[31:0];
          pbor_nxt  = p_diff[32];
          dst_nxt   = dst_node;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
        if (oor) begin
          res_oor_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          res_oor_nxt = 1'b0;
          node_re     = 1'b1;
          state_nxt   = S_RE;
        end
      end
      S_RE: begin
        node_re   = 1'b1;
        b_nxt     = (p_r == 32'd0) ? '0 :
                    local_edge(node_rdata, edge_base_r, limit_r, edge_cnt_r);
        state_nxt = S_EC;
      end
      S_EC: begin
        e_nxt     = local_edge(node_rdata, edge_base_r, limit_r, edge_cnt_r);
        issue_nxt = b_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // each read is compared in the cycle after it is issued
        if (hit) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = cmp_idx_r[15:0];
          state_nxt     = S_FIN;
        end else if (issue_ok) begin
          edge_re     = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r;
          issue_nxt   = issue_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: holds a result while the sequencer takes new writes
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_oor_nxt   = out_oor_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_FIN) && slot_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_idx_nxt   = res_idx_r;
      out_oor_nxt   = res_oor_r;
    end
  end

  // control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cmp_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      node_offset_r <= '0;
      edge_base_r   <= '0;
      edge_cnt_r    <= '0;
      num_nodes_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          cel_pkg::CFG_NODE_OFFSET: node_offset_r <= cfg_data;
          cel_pkg::CFG_EDGE_OFFSET: edge_base_r   <= cfg_data;
          cel_pkg::CFG_NUM_EDGES:   edge_cnt_r    <= cfg_data[IW-1:0];
          cel_pkg::CFG_NUM_NODES:   num_nodes_r   <= cfg_data[cel_pkg::NNODES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload and derived registers
  always_ff @(posedge clk) begin
    limit_r     <= {1'b0, edge_base_r} + {{(33-IW){1'b0}}, edge_cnt_r};
    elim_r      <= ({{(32-IW){1'b0}}, edge_cnt_r} < 32'(MAX_EDGES)) ?
                   edge_cnt_r : IW'(MAX_EDGES);
    p_r         <= p_nxt;
    pbor_r      <= pbor_nxt;
    dst_r       <= dst_nxt;
    b_r         <= b_nxt;
    e_r         <= e_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_oor_r   <= res_oor_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_oor_r, out_idx_r, out_found_r};

  // row end store: global end-edge index per local node
  cel_ram #(
    .WIDTH (32),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (wr_value),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // edge destination store: global destination id per local edge
  cel_ram #(
    .WIDTH (32),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (wr_value),
    .re    (edge_re),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

endmodule

>>> rtl/core/cel_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module cel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/cel_checker.sv
// port-level checks for csr_edge_lookup_unit, attached by bind
// depends on cel_pkg
module cel_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [cel_pkg::OP_W-1:0]        in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cel_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a hit and an out-of-range flag never come together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[17]))
    else $error("found set on out-of-range source");

  // a miss reports edge index zero
  a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("nonzero edge index without a hit");

  // in_tready is low in the cycle after a query is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == cel_pkg::OP_QUERY) |=> !in_tready)
    else $error("input taken during a query");

endmodule

bind csr_edge_lookup_unit cel_checker u_cel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
